@@ hw/rtl/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types, codes and helpers of the intel hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

	localparam int unsigned MIN_LINE  = 11;
	localparam int unsigned COUNT_MAX = 1023;
	localparam int unsigned COUNT_W   = 10;
	localparam logic [16:0] ADDR_SPAN = 17'h10000;

	localparam int unsigned OQ_DEPTH = 2;
	localparam int unsigned OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic OPC_CHAR = 1'b0;
	localparam logic OPC_END  = 1'b1;

	localparam logic [7:0] CHR_COLON = 8'h3a;
	localparam logic [7:0] CHR_CR    = 8'h0d;
	localparam logic [7:0] CHR_LF    = 8'h0a;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ESA  = 8'h02;
	localparam logic [7:0] REC_SSA  = 8'h03;
	localparam logic [7:0] REC_ELA  = 8'h04;
	localparam logic [7:0] REC_SLA  = 8'h05;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LINE,
		MODE_DONE,
		MODE_FAIL
	} mode_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_RECORD_OK,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_SHORT,
		ERR_COLON,
		ERR_NONHEX,
		ERR_COUNT,
		ERR_SEGMENT,
		ERR_STARTLIN,
		ERR_UNKNOWN,
		ERR_EOF,
		ERR_EXT,
		ERR_HIGHADDR,
		ERR_CHECKSUM
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] write_address;
		logic [7:0]  write_byte;
		err_t        error_code;
		logic [15:0] image_base;
		logic [16:0] image_size;
	} result_t;

	typedef struct packed {
		logic [OQ_CNT_W-1:0] count;
		logic                pop;
	} oq_status_t;

	// returns {valid, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ihex_core.sv @@
// ----------------------------------------------------------------------------
// ihex_core
// input register and per-character line parser state
// ----------------------------------------------------------------------------
module ihex_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             opcode,
	input  logic [7:0]       character,
	output logic             busy,
	output logic             res_valid,
	output ihex_pkg::result_t res
);
	import ihex_pkg::*;

	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  char_s1;

	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [3:0]         high_q, high_d;
	logic [7:0]         len_q, len_d;
	logic [15:0]        addr_q, addr_d;
	logic [7:0]         rkind_q, rkind_d;
	logic [7:0]         sum_q, sum_d;
	logic [15:0]        ext_q, ext_d;
	logic [15:0]        lo_q, lo_d;
	logic [16:0]        hi_q, hi_d;
	logic               seen_q, seen_d;
	err_t               fault_q, fault_d;

	logic        is_end, active, at_colon, odd;
	logic [4:0]  hex;
	logic [3:0]  nib;
	logic [7:0]  data_byte, sum_next;
	logic [8:0]  bidx, k;
	err_t        fault_char, code;
	logic        emit_write, good_line, good_data;
	logic [COUNT_W-1:0] len_chars;
	logic [16:0] data_end;
	logic [15:0] new_lo, base;
	logic [16:0] new_hi, diff, size_raw, size_rnd, size_cap;
	logic        new_seen;
	result_t     done_res;

	assign busy = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			char_s1   <= character;
		end
	end

	always_comb begin
		is_end   = (opcode_s1 == OPC_END) || (char_s1 == CHR_CR) || (char_s1 == CHR_LF);
		active   = valid_s1 && (mode_q != MODE_DONE) && (mode_q != MODE_FAIL);
		at_colon = (count_q == '0);
		odd      = count_q[0];
		hex      = hex_nibble(char_s1);
		nib      = hex[4] ? hex[3:0] : 4'h0;
		data_byte = {high_q, nib};
		sum_next  = sum_q + data_byte;
		bidx      = count_q[COUNT_W-1:1] - 9'd1;
		k         = bidx - 9'd4;

		if (at_colon) begin
			fault_char = (char_s1 != CHR_COLON) ? ERR_COLON : fault_q;
		end else begin
			fault_char = (!hex[4] && fault_q == ERR_NONE) ? ERR_NONHEX : fault_q;
		end

		emit_write = !at_colon && !odd && (bidx >= 9'd4) && (rkind_q == REC_DATA)
			&& (k < {1'b0, len_q}) && (fault_char == ERR_NONE) && (ext_q == 16'h0);
	end

	// line check at line end
	always_comb begin
		len_chars = COUNT_W'({len_q, 1'b0}) + COUNT_W'(MIN_LINE);
		code = ERR_NONE;
		if (count_q < COUNT_W'(MIN_LINE)) begin
			code = ERR_SHORT;
		end else if (fault_q != ERR_NONE) begin
			code = fault_q;
		end else if (count_q != len_chars) begin
			code = ERR_COUNT;
		end else begin
			case (rkind_q)
				REC_DATA: if (ext_q != 16'h0) code = ERR_HIGHADDR;
				REC_EOF:  if (len_q != 8'h0) code = ERR_EOF;
				REC_ESA,
				REC_SSA:  code = ERR_SEGMENT;
				REC_ELA:  if (len_q != 8'd2) code = ERR_EXT;
				REC_SLA:  code = ERR_STARTLIN;
				default:  code = ERR_UNKNOWN;
			endcase
			if (code == ERR_NONE && sum_q != 8'h0) begin
				code = ERR_CHECKSUM;
			end
		end
		good_line = active && is_end && (count_q != '0) && (code == ERR_NONE);
		good_data = good_line && (rkind_q == REC_DATA);
	end

	// image extent and done result
	always_comb begin
		data_end = {1'b0, addr_q} + {9'b0, len_q};
		new_lo   = lo_q;
		new_hi   = hi_q;
		new_seen = seen_q;
		if (good_data) begin
			new_lo   = (addr_q < lo_q) ? addr_q : lo_q;
			new_hi   = (data_end > hi_q) ? data_end : hi_q;
			new_seen = 1'b1;
		end
		base     = new_seen ? new_lo : 16'h0;
		diff     = new_hi - {1'b0, base};
		size_raw = (new_seen && new_hi > {1'b0, base}) ? diff : 17'h0;
		size_rnd = (size_raw + 17'd3) & ~17'd3;
		size_cap = (size_rnd > ADDR_SPAN) ? ADDR_SPAN : size_rnd;
		done_res = '0;
		done_res.kind       = KIND_DONE;
		done_res.image_base = base;
		done_res.image_size = size_cap;
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		high_d  = high_q;
		len_d   = len_q;
		addr_d  = addr_q;
		rkind_d = rkind_q;
		sum_d   = sum_q;
		ext_d   = ext_q;
		fault_d = fault_q;
		lo_d    = new_lo;
		hi_d    = new_hi;
		seen_d  = new_seen;
		if (active) begin
			if (is_end) begin
				if (count_q == '0) begin
					if (opcode_s1 == OPC_END) mode_d = MODE_DONE;
				end else if (code != ERR_NONE) begin
					mode_d  = MODE_FAIL;
					fault_d = code;
				end else begin
					count_d = '0;
					high_d  = 4'h0;
					sum_d   = 8'h0;
					fault_d = ERR_NONE;
					mode_d  = (rkind_q == REC_EOF || opcode_s1 == OPC_END) ? MODE_DONE : MODE_IDLE;
				end
			end else begin
				mode_d  = MODE_LINE;
				fault_d = fault_char;
				if (!at_colon) begin
					if (odd) begin
						high_d = nib;
					end else begin
						sum_d = sum_next;
						case (bidx)
							9'd0: len_d = data_byte;
							9'd1: addr_d = {data_byte, addr_q[7:0]};
							9'd2: addr_d = {addr_q[15:8], data_byte};
							9'd3: rkind_d = data_byte;
							default: begin
								if (rkind_q == REC_ELA && k == 9'd0) ext_d = {data_byte, ext_q[7:0]};
								if (rkind_q == REC_ELA && k == 9'd1) ext_d = {ext_q[15:8], data_byte};
							end
						endcase
					end
				end
				if (count_q < COUNT_W'(COUNT_MAX)) count_d = count_q + 1'b1;
			end
		end
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (valid_s1) begin
			if (mode_q == MODE_FAIL) begin
				if (opcode_s1 == OPC_END) begin
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = fault_q;
				end
			end else if (mode_q == MODE_DONE) begin
				if (opcode_s1 == OPC_END) begin
					res_valid = 1'b1;
					res       = done_res;
				end
			end else if (is_end) begin
				if (count_q == '0) begin
					if (opcode_s1 == OPC_END) begin
						res_valid = 1'b1;
						res       = done_res;
					end
				end else if (code != ERR_NONE) begin
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = code;
				end else if (rkind_q == REC_EOF || opcode_s1 == OPC_END) begin
					res_valid = 1'b1;
					res       = done_res;
				end else begin
					res_valid = 1'b1;
					res.kind  = KIND_RECORD_OK;
				end
			end else if (emit_write) begin
				res_valid         = 1'b1;
				res.kind          = KIND_WRITE;
				res.write_address = addr_q + {7'b0, k};
				res.write_byte    = data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= '0;
			high_q  <= 4'h0;
			len_q   <= 8'h0;
			addr_q  <= 16'h0;
			rkind_q <= 8'h0;
			sum_q   <= 8'h0;
			ext_q   <= 16'h0;
			lo_q    <= 16'hffff;
			hi_q    <= 17'h0;
			seen_q  <= 1'b0;
			fault_q <= ERR_NONE;
		end else if (valid_s1) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			high_q  <= high_d;
			len_q   <= len_d;
			addr_q  <= addr_d;
			rkind_q <= rkind_d;
			sum_q   <= sum_d;
			ext_q   <= ext_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			seen_q  <= seen_d;
			fault_q <= fault_d;
		end
	end

endmodule

@@ hw/rtl/ihex_out_queue.sv @@
// ----------------------------------------------------------------------------
// ihex_out_queue
// small result queue between parser and output channel
// ----------------------------------------------------------------------------
module ihex_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ihex_pkg::result_t    push_data,
	input  logic                 stall,
	output logic                 valid,
	output ihex_pkg::result_t    data,
	output ihex_pkg::oq_status_t status
);
	import ihex_pkg::*;

	result_t             mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
		return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign valid        = (count_q != '0);
	assign data         = mem_q[rd_ptr_q];
	assign pop          = valid && !stall;
	assign status.count = count_q;
	assign status.pop   = pop;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

endmodule

@@ hw/rtl/intel_hex_record_parser_top.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// path: a result passes the input register, then the result queue
// throughput: one item per cycle while in_stall is low
// a two-entry result queue lets input continue while a result waits
// reset: asynchronous, clears parser to between lines with no fault
// ----------------------------------------------------------------------------
module intel_hex_record_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] write_address,
	output logic [7:0]  write_byte,
	output logic [3:0]  error_code,
	output logic [15:0] image_base,
	output logic [16:0] image_size
);
	import ihex_pkg::*;

	logic       accept, busy, res_valid;
	result_t    res, head;
	oq_status_t oq_status;
	logic [OQ_CNT_W:0] level;

	assign level    = {1'b0, oq_status.count} + (OQ_CNT_W + 1)'(busy)
		- (OQ_CNT_W + 1)'(oq_status.pop);
	assign in_stall = (level >= (OQ_CNT_W + 1)'(OQ_DEPTH));
	assign accept   = in_valid && !in_stall;

	ihex_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.character (character),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	ihex_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.stall     (out_stall),
		.valid     (out_valid),
		.data      (head),
		.status    (oq_status)
	);

	assign kind          = head.kind;
	assign write_address = head.write_address;
	assign write_byte    = head.write_byte;
	assign error_code    = head.error_code;
	assign image_base    = head.image_base;
	assign image_size    = head.image_size;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && oq_status.count == OQ_CNT_W'(OQ_DEPTH) && !oq_status.pop))
		else $error("result queue overflow");

	a_error_coded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && head.kind == KIND_ERROR) |-> (head.error_code != ERR_NONE))
		else $error("error result without code");

	a_size_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && head.kind == KIND_DONE)
		|-> (head.image_size[1:0] == 2'b00 && head.image_size <= ADDR_SPAN))
		else $error("image size misaligned or too large");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_WRITE) |-> $past(accept))
		else $error("write result without a preceding item");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// testbench for intel_hex_record_parser_top
// Hex record text is sent one character per item. Most lines are
// well-formed data and extended linear address records with random content,
// line endings and letter case. A predictor built into the testbench tracks
// the parser and queues the write, record ok, done and error results that
// each item should produce. A checker compares every result taken from the
// block with the oldest queued one, field by field. Errors and the done
// state last until reset, so each run ends on one terminal case drawn at
// random, then characters to be ignored and end items repeating the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import ihex_pkg::*;

	typedef enum int {
		END_EOF_RECORD,
		END_STREAM_IDLE,
		END_STREAM_MID_LINE,
		END_SHORT,
		END_NO_COLON,
		END_BAD_DIGIT,
		END_COUNT,
		END_LONG_LINE,
		END_SEGMENT,
		END_START_LINEAR,
		END_UNKNOWN_TYPE,
		END_EOF_COUNT,
		END_EXT_COUNT,
		END_HIGH_ADDRESS,
		END_CHECKSUM
	} ending_t;

	localparam int RANDOM_ITEMS = 180;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OPC_CHAR;
	logic [7:0]  character = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [15:0] write_address;
	logic [7:0]  write_byte;
	logic [3:0]  error_code;
	logic [15:0] image_base;
	logic [16:0] image_size;

	// parser state as predicted
	mode_t       mode;
	logic [9:0]  char_cnt;
	logic [3:0]  hi_nib;
	logic [7:0]  rec_len;
	logic [15:0] rec_addr;
	logic [7:0]  rec_type;
	logic [7:0]  byte_sum;
	logic [15:0] ela_base;
	logic [15:0] low_addr;
	logic [16:0] top_end;
	logic        have_data;
	err_t        line_err;

	result_t     due_results[$];
	result_t     due;
	int          fail_count = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          stall_run = 0;
	logic [15:0] addr_window;

	intel_hex_record_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.character     (character),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.write_address (write_address),
		.write_byte    (write_byte),
		.error_code    (error_code),
		.image_base    (image_base),
		.image_size    (image_size)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic reset_parser_state();
		mode = MODE_IDLE;
		char_cnt = '0;
		hi_nib = '0;
		rec_len = '0;
		rec_addr = '0;
		rec_type = '0;
		byte_sum = '0;
		ela_base = '0;
		low_addr = 16'hFFFF;
		top_end = '0;
		have_data = 1'b0;
		line_err = ERR_NONE;
	endtask

	function automatic int digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic result_t fault_result(input err_t code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t done_result();
		result_t r;
		logic [15:0] base;
		logic [17:0] span;
		r = '0;
		base = have_data ? low_addr : 16'h0000;
		span = '0;
		if (have_data && top_end > {1'b0, base}) span = top_end - base;
		span = (span + 18'd3) & ~18'd3;
		if (span > ADDR_SPAN) span = ADDR_SPAN;
		r.kind = KIND_DONE;
		r.image_base = base;
		r.image_size = span[16:0];
		return r;
	endfunction

	// checks a finished line, updates the image bounds on a good data record
	function automatic err_t line_verdict(output bit is_eof);
		logic [16:0] rec_end;
		is_eof = 1'b0;
		if (char_cnt < MIN_LINE) return ERR_SHORT;
		if (line_err != ERR_NONE) return line_err;
		if (int'(char_cnt) != int'(rec_len) * 2 + int'(MIN_LINE)) return ERR_COUNT;
		case (rec_type)
		REC_DATA: if (ela_base != 16'h0000) return ERR_HIGHADDR;
		REC_EOF: if (rec_len != 8'h00) return ERR_EOF;
		REC_ESA, REC_SSA: return ERR_SEGMENT;
		REC_ELA: if (rec_len != 8'd2) return ERR_EXT;
		REC_SLA: return ERR_STARTLIN;
		default: return ERR_UNKNOWN;
		endcase
		if (byte_sum != 8'h00) return ERR_CHECKSUM;
		if (rec_type == REC_DATA) begin
			rec_end = {1'b0, rec_addr} + {9'b0, rec_len};
			if (rec_addr < low_addr) low_addr = rec_addr;
			if (rec_end > top_end) top_end = rec_end;
			have_data = 1'b1;
		end
		is_eof = (rec_type == REC_EOF);
		return ERR_NONE;
	endfunction

	function automatic bit parser_step(input logic op, input logic [7:0] c,
			output result_t r);
		bit is_eof;
		err_t code;
		int dv;
		logic [3:0] nib;
		logic [7:0] bval;
		int bidx;
		int k;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (mode == MODE_FAIL || mode == MODE_DONE) begin
			if (op != OPC_END) return 1'b0;
			r = (mode == MODE_FAIL) ? fault_result(line_err) : done_result();
			return 1'b1;
		end
		if (op == OPC_END || c == CHR_CR || c == CHR_LF) begin
			if (char_cnt == '0) begin
				if (op == OPC_CHAR) return 1'b0;
				mode = MODE_DONE;
				r = done_result();
				return 1'b1;
			end
			code = line_verdict(is_eof);
			if (code != ERR_NONE) begin
				mode = MODE_FAIL;
				line_err = code;
				r = fault_result(code);
				return 1'b1;
			end
			char_cnt = '0;
			hi_nib = '0;
			byte_sum = '0;
			line_err = ERR_NONE;
			mode = MODE_IDLE;
			if (is_eof || op == OPC_END) begin
				mode = MODE_DONE;
				r = done_result();
				return 1'b1;
			end
			r.kind = KIND_RECORD_OK;
			return 1'b1;
		end
		mode = MODE_LINE;
		if (char_cnt == '0) begin
			if (c != CHR_COLON) line_err = ERR_COLON;
		end else begin
			dv = digit_value(c);
			nib = 4'h0;
			if (dv < 0) begin
				if (line_err == ERR_NONE) line_err = ERR_NONHEX;
			end else begin
				nib = 4'(dv);
			end
			if (char_cnt[0]) begin
				hi_nib = nib;
			end else begin
				bval = {hi_nib, nib};
				bidx = (int'(char_cnt) - 2) / 2;
				byte_sum = byte_sum + bval;
				case (bidx)
				0: rec_len = bval;
				1: rec_addr[15:8] = bval;
				2: rec_addr[7:0] = bval;
				3: rec_type = bval;
				default: begin
					k = bidx - 4;
					if (rec_type == REC_DATA && k < int'(rec_len) && line_err == ERR_NONE
							&& ela_base == 16'h0000) begin
						r.kind = KIND_WRITE;
						r.write_address = rec_addr + 16'(k);
						r.write_byte = bval;
						hit = 1'b1;
					end
					if (rec_type == REC_ELA && k == 0) ela_base[15:8] = bval;
					if (rec_type == REC_ELA && k == 1) ela_base[7:0] = bval;
				end
				endcase
			end
		end
		if (char_cnt < COUNT_MAX) char_cnt = char_cnt + 10'd1;
		return hit;
	endfunction

	task automatic push_item(input logic op, input logic [7:0] c);
		int idle_len;
		bit took;
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			idle_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle_len > 0) begin
				in_valid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		opcode <= op;
		character <= c;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		burst_left--;
		items_sent++;
		if (parser_step(op, c, r)) due_results.push_back(r);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] junk_char(input bit allow_hex);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CHR_COLON || c == CHR_CR || c == CHR_LF
				|| (!allow_hex && digit_value(c) >= 0));
		return c;
	endfunction

	task automatic random_payload(input int len, output logic [7:0] q[$]);
		q.delete();
		repeat (len) begin
			case ($urandom_range(0, 7))
			0: q.push_back(8'h00);
			1: q.push_back(8'hFF);
			default: q.push_back(8'($urandom));
			endcase
		end
	endtask

	task automatic build_record(input logic [7:0] rtype, input logic [15:0] addr,
			input logic [7:0] payload[$], input logic [7:0] count_adj,
			input logic [7:0] sum_adj, output logic [7:0] text[$]);
		logic [7:0] fields[$];
		logic [7:0] sum;
		fields.push_back(8'(payload.size()) + count_adj);
		fields.push_back(addr[15:8]);
		fields.push_back(addr[7:0]);
		fields.push_back(rtype);
		foreach (payload[i]) fields.push_back(payload[i]);
		sum = 8'h00;
		foreach (fields[i]) sum = sum + fields[i];
		fields.push_back(8'h00 - sum + sum_adj);
		text.delete();
		text.push_back(CHR_COLON);
		foreach (fields[i]) begin
			text.push_back(hex_char(fields[i][7:4]));
			text.push_back(hex_char(fields[i][3:0]));
		end
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		foreach (text[i]) push_item(OPC_CHAR, text[i]);
	endtask

	task automatic end_line();
		case ($urandom_range(0, 3))
		0: push_item(OPC_CHAR, CHR_CR);
		1: push_item(OPC_CHAR, CHR_LF);
		2: begin
			push_item(OPC_CHAR, CHR_CR);
			push_item(OPC_CHAR, CHR_LF);
		end
		default: begin
			// blank lines after the record
			push_item(OPC_CHAR, CHR_LF);
			push_item(OPC_CHAR, CHR_LF);
			push_item(OPC_CHAR, CHR_CR);
		end
		endcase
	endtask

	task automatic close_line();
		if ($urandom_range(0, 3) == 0) begin
			push_item(OPC_END, 8'($urandom));
		end else begin
			end_line();
		end
	endtask

	task automatic send_record(input logic [7:0] rtype, input logic [15:0] addr,
			input logic [7:0] payload[$]);
		logic [7:0] text[$];
		build_record(rtype, addr, payload, 8'h00, 8'h00, text);
		send_text(text);
		end_line();
	endtask

	task automatic test_directed_records();
		logic [7:0] data[$];
		push_item(OPC_CHAR, CHR_CR);
		push_item(OPC_CHAR, CHR_LF);
		data.delete();
		send_record(REC_DATA, 16'($urandom), data);
		data = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
		send_record(REC_DATA, ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom), data);
		// writes wrap past the top of the address space
		data = '{8'h01, 8'h02, 8'h03, 8'h04};
		send_record(REC_DATA, 16'hFFFE, data);
		// linear base loaded, then cleared again
		data = '{8'h12, 8'h34};
		send_record(REC_ELA, 16'h0000, data);
		data = '{8'h00, 8'h00};
		send_record(REC_ELA, 16'hFFFF, data);
		random_payload(255, data);
		send_record(REC_DATA, 16'($urandom), data);
	endtask

	task automatic test_random_records();
		logic [7:0] data[$];
		logic [15:0] addr;
		int start_count;
		int len;
		start_count = items_sent;
		addr_window = 16'($urandom);
		while (items_sent - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) != 0) begin
					data = '{8'($urandom), 8'($urandom)};
					send_record(REC_ELA, 16'($urandom), data);
				end
				data = '{8'h00, 8'h00};
				send_record(REC_ELA, 16'($urandom), data);
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
					: $urandom_range(0, 16);
				random_payload(len, data);
				addr = ($urandom_range(0, 7) == 0) ? 16'($urandom)
					: addr_window + 16'($urandom_range(0, 1023));
				send_record(REC_DATA, addr, data);
			end
		end
	endtask

	task automatic test_terminal_case();
		ending_t ending;
		logic [7:0] data[$];
		logic [7:0] text[$];
		int n;
		ending = ending_t'($urandom_range(0, int'(END_CHECKSUM)));
		random_payload($urandom_range(1, 8), data);
		case (ending)
		END_EOF_RECORD: begin
			data.delete();
			send_record(REC_EOF, 16'h0000, data);
		end
		END_STREAM_IDLE: push_item(OPC_END, 8'($urandom));
		END_STREAM_MID_LINE: begin
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'h00, text);
			send_text(text);
			push_item(OPC_END, 8'($urandom));
		end
		END_SHORT: begin
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'h00, text);
			n = $urandom_range(1, MIN_LINE - 1);
			text = text[0:n-1];
			send_text(text);
			close_line();
		end
		END_NO_COLON: begin
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'h00, text);
			text[0] = junk_char(1'b1);
			send_text(text);
			close_line();
		end
		END_BAD_DIGIT: begin
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'h00, text);
			text[$urandom_range(1, text.size() - 1)] = junk_char(1'b0);
			send_text(text);
			close_line();
		end
		END_COUNT: begin
			build_record(REC_DATA, 16'($urandom), data,
				($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFF, 8'h00, text);
			send_text(text);
			close_line();
		end
		END_LONG_LINE: begin
			text.delete();
			text.push_back(CHR_COLON);
			repeat (1100) text.push_back(hex_char(4'($urandom)));
			send_text(text);
			close_line();
		end
		END_SEGMENT: begin
			build_record(($urandom_range(0, 1) != 0) ? REC_ESA : REC_SSA, 16'h0000, data,
				8'h00, 8'h00, text);
			send_text(text);
			close_line();
		end
		END_START_LINEAR: begin
			build_record(REC_SLA, 16'h0000, data, 8'h00, 8'h00, text);
			send_text(text);
			close_line();
		end
		END_UNKNOWN_TYPE: begin
			build_record(8'($urandom_range(6, 255)), 16'($urandom), data, 8'h00, 8'h00,
				text);
			send_text(text);
			close_line();
		end
		END_EOF_COUNT: begin
			build_record(REC_EOF, 16'h0000, data, 8'h00, 8'h00, text);
			send_text(text);
			close_line();
		end
		END_EXT_COUNT: begin
			n = $urandom_range(0, 3);
			if (n >= 2) n++;
			random_payload(n, data);
			build_record(REC_ELA, 16'h0000, data, 8'h00, 8'h00, text);
			send_text(text);
			close_line();
		end
		END_HIGH_ADDRESS: begin
			data = '{8'($urandom_range(1, 255)), 8'($urandom)};
			send_record(REC_ELA, 16'h0000, data);
			random_payload($urandom_range(1, 8), data);
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'h00, text);
			send_text(text);
			close_line();
		end
		default: begin
			build_record(REC_DATA, 16'($urandom), data, 8'h00, 8'($urandom_range(1, 255)),
				text);
			send_text(text);
			close_line();
		end
		endcase
	endtask

	task automatic test_after_end();
		repeat (40) push_item(OPC_CHAR, 8'($urandom));
		push_item(OPC_CHAR, 8'h00);
		push_item(OPC_CHAR, 8'hFF);
		push_item(OPC_END, 8'hFF);
		push_item(OPC_CHAR, CHR_LF);
		push_item(OPC_END, 8'h00);
	endtask

	// receiver: long free stretches, short hard stalls and choppy runs
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			case ($urandom_range(0, 3))
			0: begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(20, 60);
			end
			1: begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(1, 8);
			end
			default: begin
				out_stall <= 1'($urandom_range(0, 1));
				stall_run <= $urandom_range(0, 3);
			end
			endcase
		end
	end

	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result with nothing expected: kind %0d", kind);
				fail_count++;
			end else begin
				due = due_results.pop_front();
				check_field("kind", due.kind, kind);
				check_field("write_address", due.write_address, write_address);
				check_field("write_byte", due.write_byte, write_byte);
				check_field("error_code", due.error_code, error_code);
				check_field("image_base", due.image_base, image_base);
				check_field("image_size", due.image_size, image_size);
			end
		end
	end

	initial begin
		reset_parser_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_records();
		test_random_records();
		test_terminal_case();
		test_after_end();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("intel_hex_record_parser_top verification clean");
		end else begin
			$display("intel_hex_record_parser_top verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("intel_hex_record_parser_top verification failed");
		$finish;
	end

endmodule

@@ intel_hex_record_parser_top.f @@
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_core.sv
hw/rtl/ihex_out_queue.sv
hw/rtl/intel_hex_record_parser_top.sv
tb/tb.sv
